### rtl/ltfc_pkg.sv
`default_nettype none

package ltfc_pkg;

  // Parse phase, one-hot
  typedef enum logic [2:0] {
    PH_HDR_HI = 3'b001,
    PH_HDR_LO = 3'b010,
    PH_VALUE  = 3'b100
  } phase_t;

  // Fault codes
  localparam logic [2:0] FAULT_NONE      = 3'd0;
  localparam logic [2:0] FAULT_TRUNC     = 3'd1;
  localparam logic [2:0] FAULT_EARLY_END = 3'd2;
  localparam logic [2:0] FAULT_POSITION  = 3'd3;
  localparam logic [2:0] FAULT_LENGTH    = 3'd4;
  localparam logic [2:0] FAULT_ADDRESS   = 3'd5;

  // TLV types
  localparam logic [6:0] KIND_END     = 7'd0;
  localparam logic [6:0] KIND_CHASSIS = 7'd1;
  localparam logic [6:0] KIND_PORT    = 7'd2;
  localparam logic [6:0] KIND_TTL     = 7'd3;
  localparam logic [6:0] KIND_CAPS    = 7'd7;
  localparam logic [6:0] KIND_MGMT    = 7'd8;
  localparam logic [6:0] KIND_ORG     = 7'd127;

  // Subtypes that carry a MAC or a network address
  localparam logic [7:0] CHASSIS_SUB_MAC = 8'd4;
  localparam logic [7:0] CHASSIS_SUB_NET = 8'd5;
  localparam logic [7:0] PORT_SUB_MAC    = 8'd3;
  localparam logic [7:0] PORT_SUB_NET    = 8'd4;

  // Address families
  localparam logic [7:0] AF_IPV4 = 8'd1;
  localparam logic [7:0] AF_IPV6 = 8'd2;
  localparam logic [7:0] AF_802  = 8'd6;

  localparam logic [8:0] MGMT_MAX_LENGTH = 9'd167;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic        record_kind;
    logic [6:0]  tlv_kind;
    logic [8:0]  tlv_length;
    logic [7:0]  tlv_position;
    logic [7:0]  sub_kind;
    logic [31:0] field_value;
    logic        frame_ok;
    logic [2:0]  fault_code;
    logic        final_result;
  } result_t;

  // Up to two results per input beat, first in order in 'first'
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Address string check: family byte then address
  function automatic logic net_fail(input logic [8:0] n, input logic [7:0] af);
    logic [8:0] m;
    m = n - 9'd1;
    return (n == 9'd0) ||
           (af == AF_IPV4 && m < 9'd4) ||
           (af == AF_IPV6 && m < 9'd16) ||
           (af == AF_802 && m < 9'd6);
  endfunction

  function automatic logic [2:0] tlv_fault(
    input logic [6:0] kind,
    input logic [8:0] len,
    input logic [7:0] sub,
    input logic [7:0] af,
    input logic [7:0] al,
    input logic [7:0] oid,
    input logic [7:0] counter
  );
    logic [9:0] len_w;
    logic [9:0] al_w;
    logic       is_chassis;
    len_w      = {1'b0, len};
    al_w       = {2'b0, al};
    is_chassis = (kind == KIND_CHASSIS);
    case (kind)
      KIND_CHASSIS, KIND_PORT: begin
        if (counter != {1'b0, kind - 7'd1}) return FAULT_POSITION;
        if (len < 9'd2) return FAULT_LENGTH;
        if (sub == (is_chassis ? CHASSIS_SUB_MAC : PORT_SUB_MAC) && len < 9'd7)
          return FAULT_LENGTH;
        if (sub == (is_chassis ? CHASSIS_SUB_NET : PORT_SUB_NET))
          return net_fail(len - 9'd1, af) ? FAULT_ADDRESS : FAULT_NONE;
        return FAULT_NONE;
      end
      KIND_TTL: begin
        if (counter != 8'd2) return FAULT_POSITION;
        return (len != 9'd2) ? FAULT_LENGTH : FAULT_NONE;
      end
      KIND_CAPS: return (len != 9'd4) ? FAULT_LENGTH : FAULT_NONE;
      KIND_MGMT: begin
        if (len < 9'd9 || len > MGMT_MAX_LENGTH) return FAULT_LENGTH;
        if (len - 9'd1 < {1'b0, al}) return FAULT_LENGTH;
        if (net_fail({1'b0, al}, af)) return FAULT_ADDRESS;
        if (len_w < al_w + 10'd7) return FAULT_LENGTH;
        if ({2'b0, oid} > len_w - al_w - 10'd7) return FAULT_LENGTH;
        return FAULT_NONE;
      end
      KIND_ORG: return (len < 9'd4) ? FAULT_LENGTH : FAULT_NONE;
      default: return FAULT_NONE;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/ltfc_byte_if.sv
`default_nettype none

interface ltfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/ltfc_report_if.sv
`default_nettype none

interface ltfc_report_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [6:0]  tlv_kind;
  logic [8:0]  tlv_length;
  logic [7:0]  tlv_position;
  logic [7:0]  sub_kind;
  logic [31:0] field_value;
  logic        frame_ok;
  logic [2:0]  fault_code;
  logic        final_result;

  modport source (
    output valid, output record_kind, output tlv_kind, output tlv_length,
    output tlv_position, output sub_kind, output field_value, output frame_ok,
    output fault_code, output final_result, input ready
  );
  modport sink (
    input valid, input record_kind, input tlv_kind, input tlv_length,
    input tlv_position, input sub_kind, input field_value, input frame_ok,
    input fault_code, input final_result, output ready
  );
endinterface

`default_nettype wire

### rtl/lldp_tlv_frame_checker_unit.sv
// LLDP TLV frame checker: one payload byte per beat, parsed in a single registered pass.
// Results are registered into the result queue and read out on report from its head.
// Throughput: one byte per cycle while the queue has room; a frame_end byte closing
//   a TLV queues two results, drained one per cycle on report.ready via a four-entry queue.
// Reset (rst, synchronous, active high): parser returns to the header high byte,
//   TLV count and latched fault clear, result queue empties.
`default_nettype none

module lldp_tlv_frame_checker_unit (
  input  logic        clk,
  input  logic        rst,
  ltfc_byte_if.sink   payload,
  ltfc_report_if.source report
);
  import ltfc_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  header_high, header_high_next;
  logic [6:0]  cur_kind, cur_kind_next;
  logic [8:0]  cur_length, cur_length_next;
  logic [8:0]  value_offset, value_offset_next;
  logic [7:0]  tlv_counter, tlv_counter_next;
  logic [7:0]  cur_subtype, cur_subtype_next;
  logic [31:0] value_acc, value_acc_next;
  logic [7:0]  address_length, address_length_next;
  logic [7:0]  oid_length, oid_length_next;
  logic [7:0]  addr_family, addr_family_next;
  logic [2:0]  latched_fault, latched_fault_next;
  logic        parsing_done, parsing_done_next;

  // Per-beat working values
  logic        accept;
  logic        room;
  logic        complete;
  logic [2:0]  fault;
  logic [6:0]  hdr_kind;
  logic [8:0]  hdr_len;
  logic [8:0]  off_inc;
  logic [9:0]  rel;        // offset relative to the byte after the mgmt address
  logic        past_addr;
  logic [7:0]  rec_sub;
  logic [31:0] rec_val;
  result_t     rec;
  push_t       push;

  assign accept        = payload.valid & payload.ready;
  assign payload.ready = room;

  assign hdr_kind  = header_high[7:1];
  assign hdr_len   = {header_high[0], payload.data_byte};
  assign off_inc   = value_offset + 9'd1;
  assign rel       = {1'b0, value_offset} - {2'b0, address_length} - 10'd1;
  assign past_addr = ({1'b0, value_offset} > {2'b0, address_length});

  always_comb begin
    phase_next          = phase;
    header_high_next    = header_high;
    cur_kind_next       = cur_kind;
    cur_length_next     = cur_length;
    value_offset_next   = value_offset;
    tlv_counter_next    = tlv_counter;
    cur_subtype_next    = cur_subtype;
    value_acc_next      = value_acc;
    address_length_next = address_length;
    oid_length_next     = oid_length;
    addr_family_next    = addr_family;
    latched_fault_next  = latched_fault;
    parsing_done_next   = parsing_done;
    complete            = 1'b0;
    fault               = FAULT_NONE;
    rec_sub             = '0;
    rec_val             = '0;
    rec                 = '0;
    push                = '0;

    if (accept && !parsing_done) begin
      unique case (phase)
        PH_HDR_HI: begin
          header_high_next = payload.data_byte;
          phase_next       = PH_HDR_LO;
        end
        PH_HDR_LO: begin
          cur_kind_next       = hdr_kind;
          cur_length_next     = hdr_len;
          value_offset_next   = '0;
          cur_subtype_next    = '0;
          value_acc_next      = '0;
          address_length_next = '0;
          oid_length_next     = '0;
          addr_family_next    = '0;
          if (hdr_kind == KIND_END && hdr_len == 9'd0) begin
            // End TLV: needs the three mandatory TLVs ahead of it
            phase_next        = PH_HDR_HI;
            parsing_done_next = 1'b1;
            if (tlv_counter < 8'd3) begin
              latched_fault_next = FAULT_EARLY_END;
            end else begin
              rec.tlv_position = tlv_counter;
              rec.final_result = 1'b1;
              push.first       = rec;
              push.count       = 2'd1;
              tlv_counter_next = (tlv_counter == COUNT_MAX) ? tlv_counter
                                                             : tlv_counter + 8'd1;
            end
          end else if (hdr_len == 9'd0) begin
            complete = 1'b1;
          end else begin
            phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          case (cur_kind)
            KIND_CHASSIS, KIND_PORT: begin
              if (value_offset == 9'd0) cur_subtype_next = payload.data_byte;
              else if (value_offset == 9'd1) addr_family_next = payload.data_byte;
            end
            KIND_TTL, KIND_CAPS, KIND_ORG: begin
              if (value_offset < 9'd4) value_acc_next = {value_acc[23:0], payload.data_byte};
            end
            KIND_MGMT: begin
              if (value_offset == 9'd0) address_length_next = payload.data_byte;
              else if (value_offset == 9'd1 && address_length != 8'd0)
                addr_family_next = payload.data_byte;
              if (value_offset != 9'd0 && past_addr) begin
                if (rel == 10'd0) cur_subtype_next = payload.data_byte;
                else if (rel >= 10'd1 && rel <= 10'd4)
                  value_acc_next = {value_acc[23:0], payload.data_byte};
                else if (rel == 10'd5) oid_length_next = payload.data_byte;
              end
            end
            default: ;
          endcase
          value_offset_next = off_inc;
          if (off_inc == cur_length) complete = 1'b1;
        end
        default: phase_next = PH_HDR_HI;
      endcase

      // TLV close: checks on the updated state, record if clean
      if (complete) begin
        phase_next = PH_HDR_HI;
        fault = tlv_fault(cur_kind_next, cur_length_next, cur_subtype_next,
                          addr_family_next, address_length_next, oid_length_next,
                          tlv_counter);
        if (fault != FAULT_NONE) begin
          latched_fault_next = fault;
          parsing_done_next  = 1'b1;
        end else begin
          case (cur_kind_next)
            KIND_CHASSIS: begin
              rec_sub = cur_subtype_next;
              if (cur_subtype_next == CHASSIS_SUB_NET) rec_val = {24'd0, addr_family_next};
            end
            KIND_PORT: begin
              rec_sub = cur_subtype_next;
              if (cur_subtype_next == PORT_SUB_NET) rec_val = {24'd0, addr_family_next};
            end
            KIND_TTL, KIND_CAPS: rec_val = value_acc_next;
            KIND_MGMT: begin
              rec_sub = cur_subtype_next;
              rec_val = value_acc_next;
            end
            KIND_ORG: begin
              rec_sub = value_acc_next[7:0];
              rec_val = {8'd0, value_acc_next[31:8]};
            end
            default: ;
          endcase
          rec.tlv_kind     = cur_kind_next;
          rec.tlv_length   = cur_length_next;
          rec.tlv_position = tlv_counter;
          rec.sub_kind     = rec_sub;
          rec.field_value  = rec_val;
          rec.final_result = 1'b1;
          push.first       = rec;
          push.count       = 2'd1;
          tlv_counter_next = (tlv_counter == COUNT_MAX) ? tlv_counter
                                                         : tlv_counter + 8'd1;
        end
      end
    end

    // Frame verdict, then the frame state starts over
    if (accept && payload.frame_end) begin
      if (!parsing_done_next && phase_next == PH_VALUE) latched_fault_next = FAULT_TRUNC;
      rec              = '0;
      rec.record_kind  = 1'b1;
      rec.tlv_position = tlv_counter_next;
      rec.frame_ok     = (latched_fault_next == FAULT_NONE);
      rec.fault_code   = latched_fault_next;
      rec.final_result = 1'b1;
      if (push.count == 2'd0) begin
        push.first = rec;
        push.count = 2'd1;
      end else begin
        push.first.final_result = 1'b0;
        push.second             = rec;
        push.count              = 2'd2;
      end
      phase_next          = PH_HDR_HI;
      header_high_next    = '0;
      cur_kind_next       = '0;
      cur_length_next     = '0;
      value_offset_next   = '0;
      tlv_counter_next    = '0;
      cur_subtype_next    = '0;
      value_acc_next      = '0;
      address_length_next = '0;
      oid_length_next     = '0;
      addr_family_next    = '0;
      latched_fault_next  = FAULT_NONE;
      parsing_done_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR_HI;
      tlv_counter   <= '0;
      latched_fault <= FAULT_NONE;
      parsing_done  <= 1'b0;
    end else begin
      phase         <= phase_next;
      tlv_counter   <= tlv_counter_next;
      latched_fault <= latched_fault_next;
      parsing_done  <= parsing_done_next;
    end
  end

  // Payload state: always rewritten at a header before it is used
  always_ff @(posedge clk) begin
    header_high    <= header_high_next;
    cur_kind       <= cur_kind_next;
    cur_length     <= cur_length_next;
    value_offset   <= value_offset_next;
    cur_subtype    <= cur_subtype_next;
    value_acc      <= value_acc_next;
    address_length <= address_length_next;
    oid_length     <= oid_length_next;
    addr_family    <= addr_family_next;
  end

  ltfc_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .report (report)
  );

`ifndef NO_ASSERTIONS
  a_verdict_out: assert property (@(posedge clk) disable iff (rst)
    (accept && payload.frame_end) |=> report.valid)
    else $error("frame end beat gave no queued verdict");

  a_fault_stops: assert property (@(posedge clk) disable iff (rst)
    (latched_fault != FAULT_NONE) |-> parsing_done)
    else $error("fault latched while parser still running");

  a_value_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VALUE) |-> (cur_length != 9'd0))
    else $error("value phase with zero TLV length");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.second.record_kind && !push.first.record_kind))
    else $error("two results in one beat must be record then verdict");
`endif

endmodule

`default_nettype wire

### rtl/ltfc_result_queue.sv
`default_nettype none

module ltfc_result_queue (
  input  logic            clk,
  input  logic            rst,
  input  ltfc_pkg::push_t push,
  output logic            room,
  ltfc_report_if.source   report
);
  import ltfc_pkg::*;

  result_t           q [QDEPTH];
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W:0]   count;
  logic              pop;
  result_t           head;

  assign pop  = report.valid & report.ready;
  assign room = (count <= (QPTR_W + 1)'(QDEPTH - 2));
  assign head = q[rptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) q[wptr] <= push.first;
    if (push.count == 2'd2) q[wptr + 1'b1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push.count);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count + (QPTR_W + 1)'(push.count) - (QPTR_W + 1)'(pop);
    end
  end

  assign report.valid        = (count != '0);
  assign report.record_kind  = head.record_kind;
  assign report.tlv_kind     = head.tlv_kind;
  assign report.tlv_length   = head.tlv_length;
  assign report.tlv_position = head.tlv_position;
  assign report.sub_kind     = head.sub_kind;
  assign report.field_value  = head.field_value;
  assign report.frame_ok     = head.frame_ok;
  assign report.fault_code   = head.fault_code;
  assign report.final_result = head.final_result;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QDEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("push into result queue without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> count == $past(count) - 1'b1)
    else $error("result queue count not decremented on pop");
`endif

endmodule

`default_nettype wire
